// ----- rtl/core/mr90_pkg.sv -----
// ----------------------------------------------------------------------------
// mr90_pkg
// Shared types and constants of the 90-degree matrix rotation unit.
// ----------------------------------------------------------------------------
package mr90_pkg;

  localparam int CFG_W            = 5;
  localparam int DATA_W           = 32;
  localparam int MAX_SIDE_DEFAULT = 16;
  localparam int CMD_DEPTH        = 4;
  localparam int OUT_DEPTH        = 4;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(16);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] element_value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rotated_value;
    logic                     last_of_frame;
  } result_t;

endpackage

// ----- rtl/core/mr90_ram.sv -----
// ----------------------------------------------------------------------------
// mr90_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mr90_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/mr90_fifo.sv -----
// ----------------------------------------------------------------------------
// mr90_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module mr90_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/mr90_front.sv -----
// ----------------------------------------------------------------------------
// mr90_front
// Accepts items, tracks the load and readout positions and turns each item
// into a store command with its frame store address.
// ----------------------------------------------------------------------------
module mr90_front #(
  parameter int MAX_SIDE = mr90_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic [mr90_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  push,
  input  mr90_pkg::item_t                       item,
  input  logic                                  cmd_full,
  output logic                                  cmd_push,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)+mr90_pkg::DATA_W+1:0] cmd_data
);

  import mr90_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int ADDR_W = $clog2(MAX_SIDE*MAX_SIDE);
  localparam int SB     = $clog2(MAX_SIDE+1);
  localparam int SW     = (SB > CFG_W) ? SB : CFG_W;

  logic [CFG_W-1:0] matrix_size;
  logic [IDX_W-1:0] load_row;
  logic [IDX_W-1:0] load_col;
  logic [IDX_W-1:0] read_row;
  logic [IDX_W-1:0] read_col;

  logic [SW-1:0]     side;
  logic [SW-1:0]     size_ext;
  logic              load_col_wrap;
  logic              load_row_wrap;
  logic              read_col_wrap;
  logic              read_row_wrap;
  logic [IDX_W-1:0]  src_row;
  logic [ADDR_W-1:0] load_addr;
  logic [ADDR_W-1:0] read_addr;
  logic              is_read;
  logic              last;

  // A size of zero acts as one; sizes beyond the store saturate.
  assign size_ext = SW'(matrix_size);
  always_comb begin
    priority if (size_ext == '0) begin
      side = SW'(1);
    end else if (size_ext > SW'(MAX_SIDE)) begin
      side = SW'(MAX_SIDE);
    end else begin
      side = size_ext;
    end
  end

  assign load_col_wrap = (SW'(load_col) + SW'(1) >= side);
  assign load_row_wrap = (SW'(load_row) + SW'(1) >= side);
  assign read_col_wrap = (SW'(read_col) + SW'(1) >= side);
  assign read_row_wrap = (SW'(read_row) + SW'(1) >= side);

  // Rotated position (r,c) reads stored element (n-1-c, r).
  assign src_row   = IDX_W'(side - SW'(1) - SW'(read_col));
  assign load_addr = ADDR_W'(load_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(load_col);
  assign read_addr = ADDR_W'(src_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(read_row);

  assign is_read  = (item.opcode == OP_READ);
  assign last     = is_read && read_col_wrap && read_row_wrap;
  assign cmd_push = push && !cmd_full;
  assign cmd_data = {is_read, last, is_read ? read_addr : load_addr,
                     item.element_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
      load_row    <= '0;
      load_col    <= '0;
      read_row    <= '0;
      read_col    <= '0;
    end else if (cfg_valid) begin
      matrix_size <= cfg_data;
      load_row    <= '0;
      load_col    <= '0;
      read_row    <= '0;
      read_col    <= '0;
    end else if (cmd_push) begin
      if (is_read) begin
        read_col <= read_col_wrap ? '0 : read_col + IDX_W'(1);
        if (read_col_wrap) begin
          read_row <= read_row_wrap ? '0 : read_row + IDX_W'(1);
        end
      end else begin
        load_col <= load_col_wrap ? '0 : load_col + IDX_W'(1);
        if (load_col_wrap) begin
          load_row <= load_row_wrap ? '0 : load_row + IDX_W'(1);
        end
      end
    end
  end

  a_load_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    SW'(load_col) < side) else $error("load column beyond side");
  a_read_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    SW'(read_col) < side) else $error("read column beyond side");
  a_read_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    SW'(read_row) < side) else $error("read row beyond side");
  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> (load_row == '0 && load_col == '0 && read_row == '0 && read_col == '0))
    else $error("size write did not restart positions");

endmodule

// ----- rtl/core/mr90_back.sv -----
// ----------------------------------------------------------------------------
// mr90_back
// Executes store commands in order against the frame store and queues the
// read results for the consumer.
// ----------------------------------------------------------------------------
module mr90_back #(
  parameter int MAX_SIDE = mr90_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cmd_empty,
  input  logic [$clog2(MAX_SIDE*MAX_SIDE)+mr90_pkg::DATA_W+1:0] cmd_data,
  output logic                                  cmd_pop,
  output logic                                  empty,
  input  logic                                  pop,
  output mr90_pkg::result_t                     result
);

  import mr90_pkg::*;

  localparam int ADDR_W = $clog2(MAX_SIDE*MAX_SIDE);
  localparam int RES_W  = $bits(result_t);
  localparam int OCW    = $clog2(OUT_DEPTH+1);

  logic              cmd_is_read;
  logic              cmd_last;
  logic [ADDR_W-1:0] cmd_addr;
  logic [DATA_W-1:0] cmd_value;
  logic [DATA_W-1:0] rdata;
  logic              rd_pend;
  logic              rd_last;
  logic              room;
  logic              out_full;
  logic [OCW-1:0]    out_count;
  logic [RES_W-1:0]  out_din;
  logic [RES_W-1:0]  out_dout;

  assign cmd_is_read = cmd_data[ADDR_W+DATA_W+1];
  assign cmd_last    = cmd_data[ADDR_W+DATA_W];
  assign cmd_addr    = cmd_data[ADDR_W+DATA_W-1:DATA_W];
  assign cmd_value   = cmd_data[DATA_W-1:0];

  // A read may issue only if its result is sure of a slot when it returns.
  assign room    = ((OCW+1)'(out_count) + (OCW+1)'(rd_pend)) < (OCW+1)'(OUT_DEPTH);
  assign cmd_pop = !cmd_empty && (!cmd_is_read || room);

  mr90_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_SIDE*MAX_SIDE)
  ) u_store (
    .clk   (clk),
    .we    (cmd_pop && !cmd_is_read),
    .addr  (cmd_addr),
    .wdata (cmd_value),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      rd_last <= 1'b0;
    end else begin
      rd_pend <= cmd_pop && cmd_is_read;
      rd_last <= cmd_last;
    end
  end

  assign out_din = {rdata, rd_last};

  mr90_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rd_pend),
    .din   (out_din),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_dout),
    .empty (empty),
    .count (out_count)
  );

  assign result = result_t'(out_dout);

  a_no_result_drop: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !out_full) else $error("read result arrived at a full queue");
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    ((OCW+1)'(out_count) + (OCW+1)'(rd_pend)) <= (OCW+1)'(OUT_DEPTH))
    else $error("result credits exceeded");
  a_pend_from_read: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(cmd_pop && cmd_is_read)) else $error("stray read result");

endmodule

// ----- rtl/core/matrix_rotate_90_unit.sv -----
// A read transaction passes the command queue, the frame store read and the result queue.
// Throughput: one transaction per cycle, loads and reads alike, while the command queue is not
// full and a read finds room in the result queue; one frame store access each.
// The frame store has a single port with registered read; that port sets the rate.
// Reset clears positions and queues and sets the side to 16; store contents stay undefined.
// ----------------------------------------------------------------------------
// matrix_rotate_90_unit
// Loads a square matrix in row-major order and reads it back rotated by
// 90 degrees clockwise through readout address generation.
// ----------------------------------------------------------------------------
module matrix_rotate_90_unit #(
  parameter int MAX_SIDE = mr90_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mr90_pkg::CFG_W-1:0] cfg_data,
  input  logic                       push,
  output logic                       full,
  input  mr90_pkg::item_t            item,
  output logic                       empty,
  input  logic                       pop,
  output mr90_pkg::result_t          result
);

  import mr90_pkg::*;

  localparam int ADDR_W = $clog2(MAX_SIDE*MAX_SIDE);
  localparam int CMD_W  = ADDR_W + DATA_W + 2;

  logic                           cmd_push;
  logic                           cmd_full;
  logic                           cmd_pop;
  logic                           cmd_empty;
  logic [CMD_W-1:0]               cmd_in;
  logic [CMD_W-1:0]               cmd_out;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

  assign cfg_ready = 1'b1;
  assign full      = cmd_full;

  mr90_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in)
  );

  mr90_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  mr90_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  a_cmd_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd_count <= ($clog2(CMD_DEPTH+1))'(CMD_DEPTH)) else $error("command queue overrun");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    full |-> !cmd_push) else $error("command taken while queue full");
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    cmd_empty |-> !cmd_pop) else $error("command popped from empty queue");

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the 90-degree matrix rotation unit. Load and
// read transactions are pushed through the input queue while a transaction-level
// predictor tracks the frame store and both positions. Every popped result
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mr90_pkg::*;

  localparam int SIDE_MAX  = MAX_SIDE_DEFAULT;
  localparam int POS_W     = $clog2(SIDE_MAX);
  localparam int CELLS     = SIDE_MAX * SIDE_MAX;
  localparam int RAND_ITEMS = 30;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic             push;
  logic             full;
  item_t            item;
  logic             empty;
  logic             pop;
  result_t          result;

  matrix_rotate_90_unit #(.MAX_SIDE(SIDE_MAX)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [CFG_W-1:0]         side_q;
  logic [POS_W-1:0]         ld_row, ld_col, rd_row, rd_col;
  logic signed [DATA_W-1:0] frame_mem [CELLS];
  bit                       written_mem [CELLS];
  result_t                  rotated_q [$];

  int      errors;
  bit      tx_quiet;
  bit      rx_quiet;
  int      stall_req;
  result_t want;

  task automatic flag_error(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  function automatic int eff_side();
    if (side_q == 0) return 1;
    if (side_q > SIDE_MAX) return SIDE_MAX;
    return int'(side_q);
  endfunction

  task automatic step_pos(inout logic [POS_W-1:0] row, inout logic [POS_W-1:0] col,
                          input int n);
    if (int'(col) + 1 >= n) begin
      col = '0;
      row = (int'(row) + 1 >= n) ? '0 : row + 1'b1;
    end else begin
      col = col + 1'b1;
    end
  endtask

  function automatic int src_addr();
    return (eff_side() - 1 - int'(rd_col)) * SIDE_MAX + int'(rd_row);
  endfunction

  task automatic predict_item(input item_t it);
    int      n;
    int      addr;
    result_t r;
    n = eff_side();
    if (it.opcode == OP_LOAD) begin
      addr = int'(ld_row) * SIDE_MAX + int'(ld_col);
      frame_mem[addr]   = it.element_value;
      written_mem[addr] = 1'b1;
      step_pos(ld_row, ld_col, n);
    end else begin
      r.rotated_value = frame_mem[src_addr()];
      r.last_of_frame = (int'(rd_row) == n - 1) && (int'(rd_col) == n - 1);
      rotated_q.push_back(r);
      step_pos(rd_row, rd_col, n);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return {1'b0, {(DATA_W-1){1'b1}}};
      3:       return {1'b1, {(DATA_W-1){1'b0}}};
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t load_of(input logic signed [DATA_W-1:0] v);
    item_t it;
    it.opcode        = OP_LOAD;
    it.element_value = v;
    return it;
  endfunction

  function automatic item_t read_of();
    item_t it;
    it.opcode        = OP_READ;
    it.element_value = $urandom;
    return it;
  endfunction

  // Starts and ends at a falling edge. push stays high unless a gap follows.
  task automatic send_item(input item_t it);
    item_t it_q;
    it_q = it;
    // A read of a never-written store entry is turned into a load.
    if (it_q.opcode == OP_READ && !written_mem[src_addr()]) begin
      it_q = load_of(random_word());
    end
    push <= 1'b1;
    item <= it_q;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_item(it_q);
    @(negedge clk);
    if (!tx_quiet && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Loads leave no result behind, so a further wait follows once the predicted results have drained.
  task automatic wait_drain();
    push <= 1'b0;
    @(negedge clk);
    while (rotated_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_side(input logic [CFG_W-1:0] v);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    side_q = v;
    ld_row = '0;
    ld_col = '0;
    rd_row = '0;
    rd_col = '0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame();
    int cnt;
    cnt = eff_side() * eff_side();
    repeat (cnt) send_item(load_of(random_word()));
    repeat (cnt) send_item(read_of());
  endtask

  // Receiver: random pop gaps, plus a long hold-off on request.
  initial begin : rx_side
    int gap_left;
    int stall_left;
    gap_left   = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_req > 0) begin
        stall_left = stall_req;
        stall_req  = 0;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (gap_left > 0) begin
        pop <= 1'b0;
        gap_left--;
      end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        gap_left = $urandom_range(0, 11);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (rotated_q.size() == 0) begin
        flag_error($sformatf("result %0d/%0b with no transaction pending",
                             result.rotated_value, result.last_of_frame));
      end else begin
        want = rotated_q.pop_front();
        if (result.rotated_value !== want.rotated_value)
          flag_error($sformatf("rotated_value %0d, predicted %0d",
                               result.rotated_value, want.rotated_value));
        if (result.last_of_frame !== want.last_of_frame)
          flag_error($sformatf("last_of_frame %0b, predicted %0b",
                               result.last_of_frame, want.last_of_frame));
      end
    end
  end

  // The side after reset is the largest one; a full frame also fills the store.
  task automatic test_reset_side_frame();
    send_item(load_of('0));
    send_item(load_of('1));
    send_item(load_of({1'b0, {(DATA_W-1){1'b1}}}));
    send_item(load_of({1'b1, {(DATA_W-1){1'b0}}}));
    repeat (CELLS - 4) send_item(load_of(random_word()));
    repeat (CELLS) send_item(read_of());
  endtask

  task automatic test_corner_cases();
    // Single-element matrix, then a side of zero that acts as one.
    write_side(CFG_W'(1));
    send_item(load_of({1'b1, {(DATA_W-1){1'b0}}}));
    send_item(read_of());
    send_item(load_of({1'b0, {(DATA_W-1){1'b1}}}));
    send_item(read_of());
    send_item(read_of());
    write_side('0);
    send_item(load_of('1));
    send_item(read_of());
    // Two-by-two frame with a read that wraps into the next frame.
    write_side(CFG_W'(2));
    send_item(load_of(32'sd11));
    send_item(load_of(32'sd12));
    send_item(load_of(-32'sd21));
    send_item(load_of(-32'sd22));
    repeat (5) send_item(read_of());
    // A side above the maximum saturates.
    write_side('1);
    repeat (2) send_item(read_of());
    // Rewriting the side returns both positions to the origin; reads before
    // a full frame see older contents.
    write_side(CFG_W'(3));
    send_item(load_of(32'sd100));
    send_item(load_of(32'sd200));
    write_side(CFG_W'(3));
    send_item(load_of(32'sd300));
    repeat (3) send_item(read_of());
  endtask

  task automatic test_backpressure();
    write_side(CFG_W'(2));
    repeat (4) send_item(load_of(random_word()));
    tx_quiet  = 1'b1;
    stall_req = 200;
    repeat (20) send_item(read_of());
    tx_quiet = 1'b0;
    // The sender now holds off until every result has come out.
    wait_drain();
    repeat (10) send_item($urandom_range(0, 1) ? read_of() : load_of(random_word()));
  endtask

  task automatic test_random_frames();
    int sent;
    int pick;
    int cnt;
    logic [CFG_W-1:0] v;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) v = '0;
      else           v = CFG_W'($urandom_range(1, 4));
      write_side(v);
      repeat ($urandom_range(1, 3)) begin
        cnt  = eff_side() * eff_side();
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          send_frame();
          sent += 2 * cnt;
        end else if (pick < 9) begin
          repeat (2 * cnt) begin
            send_item($urandom_range(0, 1) ? read_of() : load_of(random_word()));
          end
          sent += 2 * cnt;
        end else begin
          // Broken frame: a load run and then a read run, each of random length up to one frame.
          repeat ($urandom_range(0, cnt)) begin
            send_item(load_of(random_word()));
            sent++;
          end
          repeat ($urandom_range(1, cnt)) begin
            send_item(read_of());
            sent++;
          end
        end
      end
    end
  endtask

  task automatic test_streaming();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    write_side(CFG_W'(4));
    send_frame();
    write_side(CFG_W'(1));
    repeat (2) send_frame();
    write_side(CFG_W'(3));
    send_frame();
  endtask

  initial begin : main
    int k;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    push      = 1'b0;
    item      = '0;
    pop       = 1'b0;
    errors    = 0;
    tx_quiet  = 1'b0;
    rx_quiet  = 1'b0;
    stall_req = 0;
    side_q    = SIZE_RESET;
    ld_row    = '0;
    ld_col    = '0;
    rd_row    = '0;
    rd_col    = '0;
    foreach (written_mem[i]) written_mem[i] = 1'b0;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_side_frame();
    test_corner_cases();
    test_backpressure();
    test_random_frames();
    test_streaming();

    push <= 1'b0;
    @(negedge clk);
    for (k = 0; k < 5000 && rotated_q.size() != 0; k++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (rotated_q.size() != 0)
      flag_error($sformatf("%0d predicted results never arrived", rotated_q.size()));

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mr90_pkg.sv
rtl/core/mr90_ram.sv
rtl/core/mr90_fifo.sv
rtl/core/mr90_front.sv
rtl/core/mr90_back.sv
rtl/core/matrix_rotate_90_unit.sv
verif/tb.sv
